>>> hdl/csc_pkg.sv
// Shared types and constants for the cruise speed controller.
package csc_pkg;

    // Event codes carried in the input tuser
    typedef enum logic [2:0] {
        CMD_PULSE   = 3'd0,
        CMD_WINDOW  = 3'd1,
        CMD_TICK    = 3'd2,
        CMD_UP      = 3'd3,
        CMD_DOWN    = 3'd4,
        CMD_ON      = 3'd5,
        CMD_OFF     = 3'd6,
        CMD_MANUAL  = 3'd7
    } cmd_t;

    // Configuration register indexes
    typedef enum logic [1:0] {
        CFG_DEADBAND    = 2'd0,
        CFG_ON_DUTY     = 2'd1,
        CFG_MAX_TARGET  = 2'd2,
        CFG_TARGET_STEP = 2'd3
    } cfg_idx_t;

    // LED patterns: bit0 red, bit1 green, bit2 blue
    localparam logic [2:0] LED_RED   = 3'b001;
    localparam logic [2:0] LED_GREEN = 3'b010;
    localparam logic [2:0] LED_BLUE  = 3'b100;

    localparam logic [6:0]  DUTY_MAX     = 7'd100;
    localparam logic [21:0] RPM_MAX      = 22'h3FFFFF;
    localparam logic [15:0] COUNT_MAX    = 16'hFFFF;
    localparam logic [9:0]  TARGET_RESET = 10'd100;
    localparam int unsigned RPM_SCALE    = 60000;

    typedef struct packed {
        logic [7:0] deadband;
        logic [6:0] on_duty;
        logic [9:0] max_target;
        logic [7:0] target_step;
    } cfg_t;

    typedef struct packed {
        logic       cruise;
        logic [9:0] target;
        logic [6:0] duty;
        logic [2:0] leds;
    } ctrl_t;

endpackage

>>> hdl/cruise_speed_controller_core.sv
// Top level of the cruise speed controller: stream ports, pipeline, PWM compare table.
// An accepted item is held in the input register, then in the result register, which
//   drives m_axis_tvalid; the input register refills as the result is taken.
// Throughput: one item per cycle while m_axis_tready is high.
// Reset (rst_n low, asynchronous): cruise off, red LED, target 100, duty 0,
//   speed and pulse count 0, config deadband 5, on-duty 80, max 300, step 10.
module cruise_speed_controller_core
#(
    parameter int unsigned PULSES_PER_REV = 11,
    parameter int unsigned WINDOW_MS      = 100,
    parameter int unsigned PWM_TOP        = 1000
)
(
    input  logic        clk,
    input  logic        rst_n,
    // input item stream
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [15:0] s_axis_tdata,   // [11:0] adc_sample, [15:12] zero
    input  logic [2:0]  s_axis_tuser,   // [2:0] command
    // result stream
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [55:0] m_axis_tdata,   // [9:0] pwm_compare, [16:10] duty_percent,
                                        // [17] led_red, [18] led_green, [19] led_blue,
                                        // [20] cruise_on, [42:21] measured_rpm,
                                        // [52:43] target_speed, [55:53] zero
    // configuration writes
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_addr,
    input  logic [9:0]  cfg_data
);

    // input register
    logic           in_valid_reg;
    csc_pkg::cmd_t  in_cmd_reg;
    logic [11:0]    in_adc_reg;

    // result register
    logic           out_valid_reg, out_valid_next;
    logic [55:0]    out_data_reg;

    logic           advance;
    csc_pkg::cfg_t  cfg;
    csc_pkg::ctrl_t ctrl_next;
    logic [21:0]    speed;
    logic [21:0]    speed_next;
    logic [9:0]     cmp_table [128];
    logic [9:0]     pwm_next;

    // an item moves from the input register to the result register when the
    // result register is empty or is being emptied this cycle
    assign advance        = in_valid_reg && (!out_valid_reg || m_axis_tready);
    assign s_axis_tready  = !in_valid_reg || advance;
    assign out_valid_next = advance || (out_valid_reg && !m_axis_tready);
    assign cfg_ready      = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (s_axis_tready)
            begin
                in_valid_reg <= s_axis_tvalid;
            end
            out_valid_reg <= out_valid_next;
        end
    end

    // payload registers, no reset needed
    always_ff @(posedge clk)
    begin
        if (s_axis_tvalid && s_axis_tready)
        begin
            in_cmd_reg <= csc_pkg::cmd_t'(s_axis_tuser);
            in_adc_reg <= s_axis_tdata[11:0];
        end
        if (advance)
        begin
            out_data_reg <= {3'b000, ctrl_next.target, speed_next, ctrl_next.cruise,
                             ctrl_next.leds, ctrl_next.duty, pwm_next};
        end
    end

    csc_cfg u_cfg
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (cfg_valid),
        .wr_addr (cfg_addr),
        .wr_data (cfg_data),
        .cfg     (cfg)
    );

    csc_speed
    #(
        .PULSES_PER_REV (PULSES_PER_REV),
        .WINDOW_MS      (WINDOW_MS)
    )
    u_speed
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .advance    (advance),
        .cmd        (in_cmd_reg),
        .speed      (speed),
        .speed_next (speed_next)
    );

    csc_ctrl u_ctrl
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .advance   (advance),
        .cmd       (in_cmd_reg),
        .adc       (in_adc_reg),
        .speed     (speed),
        .cfg       (cfg),
        .ctrl_next (ctrl_next)
    );

    // PWM compare per duty code, worked out at elaboration:
    // ticks = min(duty,100) * PWM_TOP / 100, capped at PWM_TOP-1; compare = top-1-ticks
    for (genvar d = 0; d < 128; d++)
    begin : g_cmp
        localparam longint unsigned DC    = (d > 100) ? 100 : d;
        localparam longint unsigned TICKS = (DC * longint'(PWM_TOP)) / 100;
        localparam longint unsigned TK    = (TICKS >= longint'(PWM_TOP))
                                            ? longint'(PWM_TOP) - 1 : TICKS;
        assign cmp_table[d] = 10'(longint'(PWM_TOP) - 1 - TK);
    end

    assign pwm_next = cmp_table[ctrl_next.duty];

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;

    // input side only stalls when a finished result is waiting downstream
    assert property (@(posedge clk) disable iff (!rst_n)
        !s_axis_tready |-> (in_valid_reg && out_valid_reg && !m_axis_tready))
        else $error("input stalled without a blocked result");
    assert property (@(posedge clk) disable iff (!rst_n) advance |=> out_valid_reg)
        else $error("advanced item lost before result register");

endmodule

>>> hdl/csc_cfg.sv
// Configuration registers of the cruise speed controller.
module csc_cfg
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             wr_en,
    input  logic [1:0]       wr_addr,
    input  logic [9:0]       wr_data,
    output csc_pkg::cfg_t    cfg
);

    csc_pkg::cfg_t cfg_reg;
    csc_pkg::cfg_t cfg_next;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (wr_en)
        begin
            unique case (csc_pkg::cfg_idx_t'(wr_addr))
                csc_pkg::CFG_DEADBAND:    cfg_next.deadband    = wr_data[7:0];
                csc_pkg::CFG_ON_DUTY:     cfg_next.on_duty     = wr_data[6:0];
                csc_pkg::CFG_MAX_TARGET:  cfg_next.max_target  = wr_data[9:0];
                csc_pkg::CFG_TARGET_STEP: cfg_next.target_step = wr_data[7:0];
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.deadband    <= 8'd5;
            cfg_reg.on_duty     <= 7'd80;
            cfg_reg.max_target  <= 10'd300;
            cfg_reg.target_step <= 8'd10;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

>>> hdl/csc_speed.sv
// Encoder pulse counter and RPM measurement, quotient kept as pulses arrive.
module csc_speed
#(
    parameter int unsigned PULSES_PER_REV = 11,
    parameter int unsigned WINDOW_MS      = 100
)
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          advance,
    input  csc_pkg::cmd_t cmd,
    output logic [21:0]   speed,
    output logic [21:0]   speed_next
);

    // rpm = count * 60000 / DIV; each pulse adds 60000 = STEP_Q * DIV + STEP_R
    localparam longint unsigned DIV    = longint'(PULSES_PER_REV) * longint'(WINDOW_MS);
    localparam longint unsigned STEP_Q = longint'(csc_pkg::RPM_SCALE) / DIV;
    localparam longint unsigned STEP_R = longint'(csc_pkg::RPM_SCALE) % DIV;
    localparam longint unsigned Q_MAX  = (64'd65535 * longint'(csc_pkg::RPM_SCALE)) / DIV;
    localparam int unsigned     QW     = $clog2(Q_MAX + 1);
    localparam int unsigned     RW     = $clog2(DIV + 1) + 1;

    logic [15:0]   count_reg,  count_next;
    logic [QW-1:0] quo_reg,    quo_next;
    logic [RW-1:0] rem_reg,    rem_next;
    logic [21:0]   speed_reg;
    logic [RW-1:0] rem_sum;
    logic [31:0]   quo_ext;

    always_comb
    begin
        count_next = count_reg;
        quo_next   = quo_reg;
        rem_next   = rem_reg;
        speed_next = speed_reg;
        rem_sum    = rem_reg + RW'(STEP_R);
        quo_ext    = 32'(quo_reg);
        if (cmd == csc_pkg::CMD_PULSE)
        begin
            if (count_reg != csc_pkg::COUNT_MAX)
            begin
                count_next = count_reg + 16'd1;
                if (rem_sum >= RW'(DIV))
                begin
                    rem_next = rem_sum - RW'(DIV);
                    quo_next = quo_reg + QW'(STEP_Q + 1);
                end
                else
                begin
                    rem_next = rem_sum;
                    quo_next = quo_reg + QW'(STEP_Q);
                end
            end
        end
        else if (cmd == csc_pkg::CMD_WINDOW)
        begin
            speed_next = (quo_ext > 32'(csc_pkg::RPM_MAX)) ? csc_pkg::RPM_MAX : quo_ext[21:0];
            count_next = '0;
            quo_next   = '0;
            rem_next   = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
            quo_reg   <= '0;
            rem_reg   <= '0;
            speed_reg <= '0;
        end
        else if (advance)
        begin
            count_reg <= count_next;
            quo_reg   <= quo_next;
            rem_reg   <= rem_next;
            speed_reg <= speed_next;
        end
    end

    assign speed = speed_reg;

    // remainder always reduced; an empty window carries no partial quotient
    assert property (@(posedge clk) disable iff (!rst_n) rem_reg < RW'(DIV))
        else $error("rpm remainder not reduced");
    assert property (@(posedge clk) disable iff (!rst_n)
        (count_reg == '0) |-> (quo_reg == '0 && rem_reg == '0))
        else $error("rpm accumulator out of step with pulse count");

endmodule

>>> hdl/csc_ctrl.sv
// Cruise mode, target, duty and LED control with deadband decision.
module csc_ctrl
(
    input  logic           clk,
    input  logic           rst_n,
    input  logic           advance,
    input  csc_pkg::cmd_t  cmd,
    input  logic [11:0]    adc,
    input  logic [21:0]    speed,
    input  csc_pkg::cfg_t  cfg,
    output csc_pkg::ctrl_t ctrl_next
);

    csc_pkg::ctrl_t state_reg;
    logic [9:0]  lower;
    logic [10:0] upper;
    logic [10:0] up_sum;
    logic [18:0] adc_x100;
    logic [18:0] pct_sum;
    logic [6:0]  adc_pct;
    logic [6:0]  on_duty;

    always_comb
    begin
        lower    = (state_reg.target > 10'(cfg.deadband))
                   ? state_reg.target - 10'(cfg.deadband) : 10'd0;
        upper    = 11'(state_reg.target) + 11'(cfg.deadband);
        up_sum   = 11'(state_reg.target) + 11'(cfg.target_step);
        on_duty  = (cfg.on_duty > csc_pkg::DUTY_MAX) ? csc_pkg::DUTY_MAX : cfg.on_duty;
        // x / 4095 for x below 2^24: (x + (x >> 12) + 1) >> 12
        adc_x100 = 19'(adc) * 19'd100;
        pct_sum  = adc_x100 + 19'(adc_x100[18:12]) + 19'd1;
        adc_pct  = pct_sum[18:12];

        ctrl_next = state_reg;
        unique case (cmd)
            csc_pkg::CMD_PULSE, csc_pkg::CMD_WINDOW:
            begin
            end
            csc_pkg::CMD_TICK:
            begin
                if (state_reg.cruise)
                begin
                    if (speed < 22'(lower))
                    begin
                        ctrl_next.duty = on_duty;
                        ctrl_next.leds = csc_pkg::LED_BLUE;
                    end
                    else if (speed > 22'(upper))
                    begin
                        ctrl_next.duty = 7'd0;
                        ctrl_next.leds = csc_pkg::LED_GREEN;
                    end
                end
            end
            csc_pkg::CMD_UP:
            begin
                ctrl_next.target = (up_sum <= 11'(cfg.max_target)) ? up_sum[9:0]
                                                                   : cfg.max_target;
            end
            csc_pkg::CMD_DOWN:
            begin
                ctrl_next.target = (state_reg.target >= 10'(cfg.target_step))
                                   ? state_reg.target - 10'(cfg.target_step) : 10'd0;
            end
            csc_pkg::CMD_ON:
            begin
                ctrl_next.cruise = 1'b1;
                ctrl_next.leds   = csc_pkg::LED_GREEN;
            end
            csc_pkg::CMD_OFF:
            begin
                ctrl_next.cruise = 1'b0;
                ctrl_next.duty   = 7'd0;
                ctrl_next.leds   = csc_pkg::LED_RED;
            end
            csc_pkg::CMD_MANUAL:
            begin
                if (!state_reg.cruise)
                begin
                    ctrl_next.duty = adc_pct;
                end
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg.cruise <= 1'b0;
            state_reg.target <= csc_pkg::TARGET_RESET;
            state_reg.duty   <= 7'd0;
            state_reg.leds   <= csc_pkg::LED_RED;
        end
        else if (advance)
        begin
            state_reg <= ctrl_next;
        end
    end

    // off means red alone; on never shows red
    assert property (@(posedge clk) disable iff (!rst_n)
        !state_reg.cruise |-> (state_reg.leds == csc_pkg::LED_RED))
        else $error("cruise off without red indicator");
    assert property (@(posedge clk) disable iff (!rst_n)
        state_reg.cruise |-> ($onehot(state_reg.leds) && !state_reg.leds[0]))
        else $error("bad indicator pattern in cruise mode");

endmodule
